// ===== design/dtts_pkg.sv =====
// ----------------------------------------------------------------------------
// dtts_pkg
// Shared types and constants for the duration text parser: status codes,
// character codes, unit multipliers and the saturation limit.
// ----------------------------------------------------------------------------
package dtts_pkg;

	// Width of the saturated total and of the pending number.
	localparam int unsigned DurW = 31;
	localparam logic [DurW-1:0] DUR_MAX = {DurW{1'b1}};

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_BAD = 2'd1,
		ST_OVF = 2'd2
	} status_t;

	// Character codes of the accepted alphabet.
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_S_LO = 8'h73;
	localparam logic [7:0] CH_S_UP = 8'h53;
	localparam logic [7:0] CH_M_LO = 8'h6D;
	localparam logic [7:0] CH_M_UP = 8'h4D;
	localparam logic [7:0] CH_H_LO = 8'h68;
	localparam logic [7:0] CH_H_UP = 8'h48;
	localparam logic [7:0] CH_D_LO = 8'h64;
	localparam logic [7:0] CH_D_UP = 8'h44;

	// Seconds per unit letter.
	localparam int unsigned MultW = 17;
	localparam logic [MultW-1:0] MULT_SEC  = 17'd1;
	localparam logic [MultW-1:0] MULT_MIN  = 17'd60;
	localparam logic [MultW-1:0] MULT_HOUR = 17'd3600;
	localparam logic [MultW-1:0] MULT_DAY  = 17'd86400;

endpackage

// ===== design/duration_text_to_seconds.sv =====
// ----------------------------------------------------------------------------
// duration_text_to_seconds
// Parses a duration text such as 2d5h30m10s, one character per request, into
// a saturated count of seconds with an ok / bad character / overflow status.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, except that a final character waits while an untaken result is held.
// The last character is held in the input register, and its result is then
// loaded into the result register once that register is free or being
// taken.
// Reset: arst_n clears the parse state, its status and both valid flags;
// the first character may be sent as soon as reset releases.
module duration_text_to_seconds
	import dtts_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      char_code,
	input  logic            is_last,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [DurW-1:0] total_seconds,
	output logic [1:0]      status
);

	// Input register.
	logic            vld_s1;
	logic [7:0]      char_s1;
	logic            last_s1;
	logic            adv_s1;

	// Parse state.
	logic [DurW-1:0] pend_q;
	logic [DurW-1:0] total_q;
	status_t         stat_q;

	// Next parse state.
	logic [DurW-1:0] pend_nxt;
	logic [DurW-1:0] total_nxt;
	status_t         stat_nxt;

	// Result of a text that ends with this character.
	logic [DurW-1:0] fin_total;
	status_t         fin_stat;

	// Arithmetic terms.
	logic                 is_digit;
	logic                 is_unit;
	logic [MultW-1:0]     mult;
	logic [DurW+MultW-1:0] prod;
	logic [DurW+MultW:0]   unit_sum;
	logic [DurW+3:0]       ten_sum;
	logic [DurW:0]         fin_sum;

	// Result register.
	logic            out_vld_q;
	logic [DurW-1:0] out_total_q;
	status_t         out_stat_q;

	// A non-final character always moves on; a final one needs the result slot.
	assign adv_s1   = vld_s1 && (!last_s1 || !out_vld_q || out_ready);
	assign in_ready = !vld_s1 || adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	// Classify the character and pick the unit multiplier.
	always_comb begin
		is_digit = (char_s1 >= CH_0) && (char_s1 <= CH_9);
		is_unit  = 1'b1;
		mult     = MULT_SEC;
		priority if (char_s1 == CH_S_LO || char_s1 == CH_S_UP) begin
			mult = MULT_SEC;
		end else if (char_s1 == CH_M_LO || char_s1 == CH_M_UP) begin
			mult = MULT_MIN;
		end else if (char_s1 == CH_H_LO || char_s1 == CH_H_UP) begin
			mult = MULT_HOUR;
		end else if (char_s1 == CH_D_LO || char_s1 == CH_D_UP) begin
			mult = MULT_DAY;
		end else begin
			is_unit = 1'b0;
		end
	end

	// Unit letter adds the pending number times the unit; digits shift in.
	assign prod     = {{MultW{1'b0}}, pend_q} * {{DurW{1'b0}}, mult};
	assign unit_sum = {{(MultW+1){1'b0}}, total_q} + {1'b0, prod};
	assign ten_sum  = {1'b0, pend_q, 3'b000} + {3'b000, pend_q, 1'b0}
		+ {{(DurW){1'b0}}, char_s1[3:0]};

	// Next state for one character.
	always_comb begin
		pend_nxt  = pend_q;
		total_nxt = total_q;
		stat_nxt  = stat_q;
		if (stat_q != ST_BAD) begin
			if (is_digit) begin
				if (ten_sum > {4'b0000, DUR_MAX}) begin
					pend_nxt = DUR_MAX;
					stat_nxt = ST_OVF;
				end else begin
					pend_nxt = ten_sum[DurW-1:0];
				end
			end else if (is_unit) begin
				pend_nxt = '0;
				if (unit_sum > {{(MultW+1){1'b0}}, DUR_MAX}) begin
					total_nxt = DUR_MAX;
					stat_nxt  = ST_OVF;
				end else begin
					total_nxt = unit_sum[DurW-1:0];
				end
			end else begin
				stat_nxt = ST_BAD;
			end
		end
	end

	// Digits left pending at the end count as seconds.
	assign fin_sum = {1'b0, total_nxt} + {1'b0, pend_nxt};

	always_comb begin
		fin_total = '0;
		fin_stat  = stat_nxt;
		if (stat_nxt != ST_BAD) begin
			if (fin_sum > {1'b0, DUR_MAX}) begin
				fin_total = DUR_MAX;
				fin_stat  = ST_OVF;
			end else begin
				fin_total = fin_sum[DurW-1:0];
			end
		end
	end

	// Parse state update; the final character returns it to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			total_q <= '0;
			stat_q  <= ST_OK;
		end else if (adv_s1) begin
			if (last_s1) begin
				pend_q  <= '0;
				total_q <= '0;
				stat_q  <= ST_OK;
			end else begin
				pend_q  <= pend_nxt;
				total_q <= total_nxt;
				stat_q  <= stat_nxt;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_total_q <= fin_total;
			out_stat_q  <= fin_stat;
		end
	end

	assign out_valid     = out_vld_q;
	assign total_seconds = out_total_q;
	assign status        = out_stat_q;

endmodule

// ===== design/dtts_checker.sv =====
// ----------------------------------------------------------------------------
// dtts_checker
// Port-level checks on the duration text parser, bound to the top level.
// ----------------------------------------------------------------------------
module dtts_checker
	import dtts_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic [7:0]      char_code,
	input logic            is_last,
	input logic            out_valid,
	input logic            out_ready,
	input logic [DurW-1:0] total_seconds,
	input logic [1:0]      status
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_seconds) && $stable(status))
		else $error("result changed while stalled");

	// The status of a valid result is one of the three defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_BAD || status == ST_OVF))
		else $error("undefined status code");

	// A bad character forces a zero total.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BAD |-> total_seconds == '0)
		else $error("nonzero total with bad character status");

	// Any overflow ends in a saturated total.
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OVF |-> total_seconds == DUR_MAX)
		else $error("overflow status without saturated total");

endmodule

bind duration_text_to_seconds dtts_checker u_dtts_checker (.*);

// ===== tb/sv/tb_duration_text_to_seconds.sv =====
// ----------------------------------------------------------------------------
// tb_duration_text_to_seconds
// Streams duration texts through the parser one character per request and
// checks every result against a cycle-free prediction of the parse. A short
// directed set covers units in both cases, total overflow and stray
// bytes. Random texts follow, mostly well formed with some noise and broken
// texts mixed in, under changing idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_duration_text_to_seconds;
	import dtts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RAND_CHARS = 1600;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned STUCK_LIMIT = 3000;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} char_req_t;

	typedef struct packed {
		logic [DurW-1:0] secs;
		status_t         st;
	} dur_result_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	logic [7:0]      char_code = 8'h00;
	logic            is_last = 1'b0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	logic [DurW-1:0] total_seconds;
	logic [1:0]      status;

	// Characters still to be sent and parse results still to arrive.
	char_req_t   char_q[$];
	dur_result_t result_q[$];

	// Predicted parse state.
	logic [31:0] acc_digits = '0;
	logic [31:0] acc_total = '0;
	status_t     acc_status = ST_OK;

	int unsigned n_stim = 0;
	int unsigned n_random = 0;
	int unsigned n_in = 0;
	int unsigned n_err = 0;
	int unsigned stall_left = 0;
	int unsigned stuck = 0;
	logic        hold_done = 1'b0;

	duration_text_to_seconds i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.total_seconds(total_seconds),
		.status       (status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Overflow only shows when no stray byte has been seen.
	function automatic void note_overflow();
		if (acc_status != ST_BAD) begin
			acc_status = ST_OVF;
		end
	endfunction

	// Adds the pending number times a unit to the total, saturating.
	function automatic void add_unit(input logic [MultW-1:0] mult);
		logic [63:0] sum;
		sum = 64'(acc_total) + 64'(acc_digits) * 64'(mult);
		if (sum > 64'(DUR_MAX)) begin
			acc_total = 32'(DUR_MAX);
			note_overflow();
		end else begin
			acc_total = sum[31:0];
		end
		acc_digits = '0;
	endfunction

	// Advances the predicted parse by one character and queues the result
	// when the character closes the text.
	function automatic void parse_char(input logic [7:0] c, input logic last);
		logic [63:0] wide;
		dur_result_t res;
		if (acc_status != ST_BAD) begin
			if (c >= CH_0 && c <= CH_9) begin
				wide = 64'(acc_digits) * 64'd10 + 64'(c - CH_0);
				if (wide > 64'(DUR_MAX)) begin
					acc_digits = 32'(DUR_MAX);
					note_overflow();
				end else begin
					acc_digits = wide[31:0];
				end
			end else begin
				case (c)
					CH_S_LO, CH_S_UP: add_unit(MULT_SEC);
					CH_M_LO, CH_M_UP: add_unit(MULT_MIN);
					CH_H_LO, CH_H_UP: add_unit(MULT_HOUR);
					CH_D_LO, CH_D_UP: add_unit(MULT_DAY);
					default: acc_status = ST_BAD;
				endcase
			end
		end
		if (last) begin
			// Trailing digits count as seconds.
			if (acc_status != ST_BAD) begin
				add_unit(MULT_SEC);
			end
			res.secs = (acc_status == ST_BAD) ? '0 : acc_total[DurW-1:0];
			res.st = acc_status;
			result_q = {result_q, res};
			acc_digits = '0;
			acc_total = '0;
			acc_status = ST_OK;
		end
	endfunction

	function automatic bit is_known_char(input logic [7:0] c);
		case (c)
			CH_S_LO, CH_S_UP, CH_M_LO, CH_M_UP,
			CH_H_LO, CH_H_UP, CH_D_LO, CH_D_UP: return 1'b1;
			default: return c >= CH_0 && c <= CH_9;
		endcase
	endfunction

	function automatic logic [7:0] pick_unit();
		case ($urandom_range(0, 7))
			0: return CH_S_LO;
			1: return CH_S_UP;
			2: return CH_M_LO;
			3: return CH_M_UP;
			4: return CH_H_LO;
			5: return CH_H_UP;
			6: return CH_D_LO;
			default: return CH_D_UP;
		endcase
	endfunction

	function automatic logic [7:0] pick_stray();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (is_known_char(c)) begin
			c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	task automatic push_char(input logic [7:0] c, input logic last);
		char_req_t req;
		req.code = c;
		req.last = last;
		char_q = {char_q, req};
		n_random++;
	endtask

	task automatic push_word(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_char(s[i], i == s.len() - 1);
		end
	endtask

	// One random text: mostly well formed, some pure noise, some broken.
	task automatic gen_text();
		logic [7:0] txt[$];
		int unsigned kind;
		int unsigned segs;
		int unsigned ndig;
		int unsigned pos;
		kind = $urandom_range(0, 99);
		if (kind >= 70 && kind < 85) begin
			repeat ($urandom_range(1, 6)) begin
				txt = {txt, 8'($urandom_range(0, 255))};
			end
		end else begin
			segs = $urandom_range(1, 4);
			for (int s = 0; s < segs; s++) begin
				// Long digit runs reach both kinds of overflow.
				ndig = ($urandom_range(0, 11) == 0) ? $urandom_range(5, 11) : $urandom_range(1, 3);
				repeat (ndig) begin
					txt = {txt, CH_0 + 8'($urandom_range(0, 9))};
				end
				if (s != segs - 1 || $urandom_range(0, 99) < 80) begin
					txt = {txt, pick_unit()};
				end
			end
			if (kind >= 85) begin
				pos = $urandom_range(0, txt.size() - 1);
				case ($urandom_range(0, 2))
					0: txt[pos] = pick_stray();
					1: txt.insert(pos, pick_stray());
					default: txt.insert(pos, pick_unit());
				endcase
			end
		end
		for (int i = 0; i < txt.size(); i++) begin
			push_char(txt[i], i == txt.size() - 1);
		end
	endtask

	// The run moves through three idle patterns as requests are accepted.
	function automatic int unsigned test_phase();
		if (n_in < n_stim / 3) begin
			return 0;
		end else if (n_in < 2 * n_stim / 3) begin
			return 1;
		end
		return 2;
	endfunction

	function automatic int unsigned tx_idle_pct();
		case (test_phase())
			0: return 34;
			1: return 54;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned rx_idle_pct();
		case (test_phase())
			0: return 54;
			1: return 34;
			default: return 0;
		endcase
	endfunction

	task automatic flag_error(input string msg);
		if (n_err < 10) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
		n_err++;
	endtask

	// Request driver: predicts each accepted character and offers the next.
	always @(posedge clk or negedge arst_n) begin : drive_p
		char_req_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_code <= 8'h00;
			is_last <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				parse_char(char_code, is_last);
				n_in <= n_in + 1;
			end
			if (!in_valid || in_ready) begin
				if (char_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
					req = char_q.pop_front();
					in_valid <= 1'b1;
					char_code <= req.code;
					is_last <= req.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each result and throttles the output side,
	// including one long hold-off that backs the parser up into its input.
	always @(posedge clk or negedge arst_n) begin : watch_p
		dur_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					flag_error($sformatf("unexpected result: total_seconds %0d status %0d",
						total_seconds, status));
				end else begin
					want = result_q.pop_front();
					if (total_seconds !== want.secs) begin
						flag_error($sformatf("total_seconds expected %0d got %0d",
							want.secs, total_seconds));
					end
					if (status !== want.st) begin
						flag_error($sformatf("status expected %0d got %0d", want.st, status));
					end
				end
			end
			if (!hold_done && test_phase() == 1) begin
				hold_done <= 1'b1;
				stall_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_idle_pct());
			end
		end
	end

	// Watchdog: ends the run when work is outstanding but nothing moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)
					|| (n_in == n_stim && result_q.size() == 0)) begin
				stuck <= 0;
			end else if (stuck >= STUCK_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				stuck <= stuck + 1;
			end
		end
	end

	initial begin
		// Directed texts: every unit in both cases, total overflow, and stray
		// bytes at both ends of the byte range.
		push_word("2d5h30m10s");
		push_word("9H1M");
		push_word("3S");
		push_word("24856D");
		push_char(8'h00, 1'b1);
		push_char(CH_0 + 8'd5, 1'b0);
		push_char(8'hFF, 1'b1);

		n_random = 0;
		while (n_random < RAND_CHARS) begin
			gen_text();
		end
		n_stim = char_q.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (n_in != n_stim || result_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_err == 0 && result_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
